### rtl/core/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Types and constants shared by the startup sequencer modules.
// ----------------------------------------------------------------------------
package esc_pkg;

	typedef enum logic [2:0] {
		ACT_SAMPLE = 3'd0,
		ACT_ARM    = 3'd1,
		ACT_BFAULT = 3'd2,
		ACT_STOP   = 3'd3,
		ACT_RUN    = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_ARMED   = 3'd1,
		MODE_STARTUP = 3'd2,
		MODE_RUNNING = 3'd3,
		MODE_FAULT   = 3'd4
	} mode_t;

	localparam logic [1:0] FLT_NONE  = 2'd0;
	localparam logic [1:0] FLT_STALL = 2'd1;
	localparam logic [1:0] FLT_BOARD = 2'd2;

	localparam logic [2:0] REG_DEADBAND    = 3'd0;
	localparam logic [2:0] REG_FULL_STEP   = 3'd1;
	localparam logic [2:0] REG_RAMP_STEP   = 3'd2;
	localparam logic [2:0] REG_ALIGN_TICKS = 3'd3;
	localparam logic [2:0] REG_SLOW_DIV    = 3'd4;
	localparam logic [2:0] REG_ARM_TICKS   = 3'd5;
	localparam logic [2:0] REG_STALL_SPEED = 3'd6;
	localparam logic [2:0] REG_STALL_TICKS = 3'd7;

	localparam int          ADC_W    = 12;
	localparam logic [11:0] ADC_FULL = 12'd4095;
	localparam logic [11:0] ADC_MID  = 12'd2048;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPDATE,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic update;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
	} ctrl_stat_t;

endpackage

### rtl/core/esc_if.sv
// ----------------------------------------------------------------------------
// esc_in_if / esc_out_if
// Valid/ready channels of the startup sequencer.
// ----------------------------------------------------------------------------
interface esc_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic [11:0]        raw_ia;
	logic [11:0]        raw_ib;
	logic [11:0]        throttle;
	logic signed [31:0] estimated_speed;
	modport source (output valid, action, raw_ia, raw_ib, throttle, estimated_speed,
		input ready);
	modport sink (input valid, action, raw_ia, raw_ib, throttle, estimated_speed,
		output ready);
endinterface

interface esc_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic [1:0]         fault_code;
	logic               calibrated;
	logic               aligning;
	logic [15:0]        angle;
	logic [27:0]        speed;
	logic signed [12:0] current_a;
	logic signed [12:0] current_b;
	logic [11:0]        offset_a_out;
	logic [11:0]        offset_b_out;
	modport source (output valid, mode, fault_code, calibrated, aligning, angle, speed,
		current_a, current_b, offset_a_out, offset_b_out, input ready);
	modport sink (input valid, mode, fault_code, calibrated, aligning, angle, speed,
		current_a, current_b, offset_a_out, offset_b_out, output ready);
endinterface

### rtl/core/esc_startup_sequencer.sv
// sequence: an input transfer starts the bit-serial throttle divide, then the update,
// then the result is output; a new input is taken only once the previous result is
// taken, and that input transfer can coincide with the output transfer.
// reset: arst_n clears the mode and control state to idle, uncalibrated, offsets at ADC midpoint,
// configuration registers to their defaults
// ----------------------------------------------------------------------------
// esc_startup_sequencer
// Open-loop startup sequencer of a sensorless motor drive.
// ----------------------------------------------------------------------------
module esc_startup_sequencer
	import esc_pkg::*;
#(
	parameter int CAL_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [27:0] cfg_data,
	esc_in_if.sink      in_ch,
	esc_out_if.source   out_ch
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	esc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	esc_datapath #(.CAL_COUNT(CAL_COUNT)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.in_action    (in_ch.action),
		.in_ia        (in_ch.raw_ia),
		.in_ib        (in_ch.raw_ib),
		.in_thr       (in_ch.throttle),
		.in_est       (in_ch.estimated_speed),
		.mode         (out_ch.mode),
		.fault_code   (out_ch.fault_code),
		.calibrated   (out_ch.calibrated),
		.aligning     (out_ch.aligning),
		.angle        (out_ch.angle),
		.speed        (out_ch.speed),
		.current_a    (out_ch.current_a),
		.current_b    (out_ch.current_b),
		.offset_a_out (out_ch.offset_a_out),
		.offset_b_out (out_ch.offset_b_out)
	);

`ifndef SYNTH
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !in_ch.ready) else $error("input taken during update");
	a_out_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_ch.valid) else $error("result missing after update");
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.fault_code != FLT_NONE |-> out_ch.mode == MODE_FAULT)
		else $error("fault code outside fault mode");
`endif

endmodule

### rtl/core/esc_divider.sv
// ----------------------------------------------------------------------------
// esc_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module esc_divider
	import esc_pkg::*;
#(
	parameter int NUM_W = 40,
	parameter int DEN_W = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= fits ? (trial - {1'b0, den_q}) : trial;
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

	// last step in progress, quotient final after this edge
	assign done = busy_q && (cnt_q == CNT_W'(1));
	assign quot = quot_q;

endmodule

### rtl/core/esc_ctrl.sv
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencing state machine: accept, divide, update, present result.
// ----------------------------------------------------------------------------
module esc_ctrl
	import esc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load      = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load      = 1'b1;
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### rtl/core/esc_datapath.sv
// ----------------------------------------------------------------------------
// esc_datapath
// Configuration registers, calibration, slew, angle and mode state.
// ----------------------------------------------------------------------------
module esc_datapath
	import esc_pkg::*;
#(
	parameter int CAL_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [27:0]        cfg_data,
	input  ctrl_cmd_t          cmd,
	output ctrl_stat_t         stat,
	input  logic [2:0]         in_action,
	input  logic [11:0]        in_ia,
	input  logic [11:0]        in_ib,
	input  logic [11:0]        in_thr,
	input  logic signed [31:0] in_est,
	output logic [2:0]         mode,
	output logic [1:0]         fault_code,
	output logic               calibrated,
	output logic               aligning,
	output logic [15:0]        angle,
	output logic [27:0]        speed,
	output logic signed [12:0] current_a,
	output logic signed [12:0] current_b,
	output logic [11:0]        offset_a_out,
	output logic [11:0]        offset_b_out
);

	localparam int CNT_W  = $clog2(CAL_COUNT + 1);
	localparam int CAL_SH = $clog2(CAL_COUNT);
	localparam int SUM_W  = ADC_W + CAL_SH;
	localparam int NUM_W  = 40;
	// floor(sum / CAL_COUNT) as a reciprocal multiply, exact over the sum range
	localparam int RCP_SH = SUM_W + CAL_SH;
	localparam int RCP_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam longint unsigned RCP =
		((64'd1 << RCP_SH) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT);

	logic [11:0] deadband_q;
	logic [27:0] full_step_q;
	logic [23:0] ramp_q;
	logic [15:0] align_ticks_q;
	logic [7:0]  slow_div_q;
	logic [15:0] arm_ticks_q;
	logic [27:0] stall_speed_q;
	logic [15:0] stall_ticks_q;

	logic [2:0]         act_q;
	logic [11:0]        ia_q, ib_q, thr_q;
	logic [31:0]        est_q;

	mode_t       mode_q;
	logic [1:0]  fault_q;
	logic [SUM_W-1:0] sum_a_q, sum_b_q;
	logic [CNT_W-1:0] cnt_q;
	logic [11:0] off_a_q, off_b_q;
	logic        cal_q;
	logic [7:0]  slow_q;
	logic [15:0] arm_q, stall_q, align_q;
	logic [27:0] speed_q;
	logic [31:0] angle_q;
	logic signed [12:0] cur_a_q, cur_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q    <= 12'd100;
			full_step_q   <= 28'd8947848;
			ramp_q        <= 24'd1000;
			align_ticks_q <= 16'd4800;
			slow_div_q    <= 8'd24;
			arm_ticks_q   <= 16'd500;
			stall_speed_q <= 28'd1000000;
			stall_ticks_q <= 16'd500;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEADBAND:    deadband_q    <= cfg_data[11:0];
				REG_FULL_STEP:   full_step_q   <= cfg_data;
				REG_RAMP_STEP:   ramp_q        <= cfg_data[23:0];
				REG_ALIGN_TICKS: align_ticks_q <= cfg_data[15:0];
				REG_SLOW_DIV:    slow_div_q    <= cfg_data[7:0];
				REG_ARM_TICKS:   arm_ticks_q   <= cfg_data[15:0];
				REG_STALL_SPEED: stall_speed_q <= cfg_data;
				REG_STALL_TICKS: stall_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// target division
	logic [11:0]      thr_ex;
	logic [11:0]      den;
	logic [NUM_W-1:0] num;
	logic [NUM_W-1:0] quot;
	logic [27:0]      tgt;
	logic             below_db;
	logic             div_done;

	assign below_db = in_thr < deadband_q;
	assign thr_ex   = below_db ? 12'd0 : in_thr - deadband_q;
	assign den      = (deadband_q >= ADC_FULL) ? 12'd1 : ADC_FULL - deadband_q;
	assign num      = NUM_W'(thr_ex) * NUM_W'(full_step_q);

	esc_divider #(.NUM_W(NUM_W), .DEN_W(12)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quot   (quot)
	);

	assign stat.div_done = div_done;

	always_comb begin
		if (thr_q < deadband_q) begin
			tgt = '0;
		end else if (deadband_q >= ADC_FULL) begin
			tgt = full_step_q;
		end else begin
			tgt = quot[27:0];
		end
	end

	// slew
	logic [27:0] slewed;
	logic [27:0] diff;
	always_comb begin
		slewed = speed_q;
		diff   = '0;
		if (speed_q < tgt) begin
			diff   = tgt - speed_q;
			slewed = (diff > 28'(ramp_q)) ? speed_q + 28'(ramp_q) : tgt;
		end else if (speed_q > tgt) begin
			diff   = speed_q - tgt;
			slewed = (diff > 28'(ramp_q)) ? speed_q - 28'(ramp_q) : tgt;
		end
	end

	logic [31:0] est_mag;
	assign est_mag = est_q[31] ? (32'd0 - est_q) : est_q;

	logic [SUM_W-1:0]  sum_a_n, sum_b_n;
	logic [PROD_W-1:0] prod_a, prod_b;
	logic [CNT_W-1:0]  cnt_n;
	logic [7:0]        slow_n;
	logic [15:0]       arm_n, stall_n;
	assign sum_a_n = sum_a_q + SUM_W'(ia_q);
	assign sum_b_n = sum_b_q + SUM_W'(ib_q);
	assign prod_a  = PROD_W'(sum_a_n) * PROD_W'(RCP);
	assign prod_b  = PROD_W'(sum_b_n) * PROD_W'(RCP);
	assign cnt_n   = cnt_q + 1'b1;
	assign slow_n  = slow_q + 1'b1;
	assign arm_n   = arm_q + 1'b1;
	assign stall_n = stall_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= in_action;
			ia_q    <= in_ia;
			ib_q    <= in_ib;
			thr_q   <= in_thr;
			est_q   <= in_est;
			cur_a_q <= 13'({1'b0, in_ia} - {1'b0, off_a_q});
			cur_b_q <= 13'({1'b0, in_ib} - {1'b0, off_b_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			fault_q <= FLT_NONE;
			sum_a_q <= '0;
			sum_b_q <= '0;
			cnt_q   <= '0;
			off_a_q <= ADC_MID;
			off_b_q <= ADC_MID;
			cal_q   <= 1'b0;
			slow_q  <= '0;
			arm_q   <= '0;
			stall_q <= '0;
			align_q <= '0;
			speed_q <= '0;
			angle_q <= '0;
		end else if (cmd.update) begin
			case (act_q)
				ACT_SAMPLE: begin
					if (mode_q == MODE_IDLE || mode_q == MODE_ARMED) begin
						if (!cal_q) begin
							sum_a_q <= sum_a_n;
							sum_b_q <= sum_b_n;
							cnt_q   <= cnt_n;
							if (cnt_n >= CNT_W'(CAL_COUNT)) begin
								off_a_q <= prod_a[RCP_SH +: 12];
								off_b_q <= prod_b[RCP_SH +: 12];
								cal_q   <= 1'b1;
							end
						end
					end else if (mode_q == MODE_STARTUP) begin
						if (align_q < align_ticks_q) begin
							align_q <= align_q + 1'b1;
							angle_q <= '0;
							speed_q <= '0;
						end else begin
							speed_q <= slewed;
							angle_q <= angle_q + 32'(slewed);
						end
					end else if (mode_q == MODE_RUNNING) begin
						speed_q <= slewed;
						angle_q <= angle_q + 32'(slewed);
					end
					if (slow_n < slow_div_q) begin
						slow_q <= slow_n;
					end else begin
						slow_q <= '0;
						if (mode_q == MODE_ARMED) begin
							if (thr_q < deadband_q) begin
								if (arm_n >= arm_ticks_q) begin
									angle_q <= '0;
									speed_q <= '0;
									align_q <= '0;
									stall_q <= '0;
									arm_q   <= '0;
									mode_q  <= MODE_STARTUP;
								end else begin
									arm_q <= arm_n;
								end
							end else begin
								arm_q <= '0;
							end
						end else if (mode_q == MODE_RUNNING) begin
							if (thr_q >= deadband_q && est_mag < 32'(stall_speed_q)) begin
								if (stall_n >= stall_ticks_q) begin
									mode_q  <= MODE_FAULT;
									fault_q <= FLT_STALL;
									stall_q <= '0;
								end else begin
									stall_q <= stall_n;
								end
							end else begin
								stall_q <= '0;
							end
						end
					end
				end
				ACT_ARM: begin
					if (mode_q == MODE_IDLE) begin
						mode_q <= MODE_ARMED;
						arm_q  <= '0;
					end
				end
				ACT_BFAULT: begin
					mode_q  <= MODE_FAULT;
					fault_q <= FLT_BOARD;
				end
				ACT_STOP: begin
					mode_q  <= MODE_IDLE;
					fault_q <= FLT_NONE;
					arm_q   <= '0;
					stall_q <= '0;
					align_q <= '0;
					speed_q <= '0;
					angle_q <= '0;
				end
				ACT_RUN: begin
					if (mode_q == MODE_STARTUP) begin
						mode_q  <= MODE_RUNNING;
						stall_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign mode         = mode_q;
	assign fault_code   = fault_q;
	assign calibrated   = cal_q;
	assign aligning     = (mode_q == MODE_STARTUP) && (align_q < align_ticks_q);
	assign angle        = angle_q[31:16];
	assign speed        = speed_q;
	assign current_a    = cur_a_q;
	assign current_b    = cur_b_q;
	assign offset_a_out = off_a_q;
	assign offset_b_out = off_b_q;

endmodule
